FILE: rtl/cq_pkg.sv
// Shared constants for the circular queue: field widths, command and status codes.
package cq_pkg;

   localparam int DATA_W = 32;
   localparam int CMD_W  = 3;
   localparam int ST_W   = 2;
   localparam int CNT_W  = 5;

   localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_PEEK_REAR  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_STATUS     = 3'd4;

   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

   localparam logic [CNT_W-1:0] CAP_RESET = 5'd10;

endpackage

FILE: rtl/circular_queue.sv
// Ring-buffer queue of signed 32-bit words driven by one command per item.
// The block takes one command item every clock cycle while req_stall is low and returns its
// result item in the next cycle; the delay is the registered read of the slot memory. While
// a result is held by rsp_stall, req_stall is raised and no new item is taken. Front and rear
// pointers, the word count and the capacity live in flip-flops; the words live in a DEPTH-entry
// memory with a registered read. csr_ready is always high; writing the capacity empties the
// queue, and the value in use is the written one clamped to 1..DEPTH.
module circular_queue #(
   parameter int DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cq_pkg::CMD_W-1:0]      req_command,
   input  logic signed [cq_pkg::DATA_W-1:0] req_data_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [cq_pkg::DATA_W-1:0] rsp_value_out,
   output logic [cq_pkg::ST_W-1:0]       rsp_status,
   output logic [cq_pkg::CNT_W-1:0]      rsp_entry_count,
   output logic                          rsp_is_full,
   output logic                          rsp_is_empty,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cq_pkg::CNT_W-1:0]      csr_queue_capacity
);
   import cq_pkg::*;

   localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMPW = ((IW > CNT_W) ? IW : CNT_W) + 1;

   logic [DATA_W-1:0] slot_mem [DEPTH];

   logic [CNT_W-1:0]  cap_ff;
   logic [IW-1:0]     head_ff, head_in;
   logic [IW-1:0]     tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic              rsp_valid_ff;
   logic [ST_W-1:0]   rsp_status_ff, status_in;
   logic [CNT_W-1:0]  rsp_count_ff;
   logic              rsp_full_ff;
   logic              rsp_empty_ff;
   logic              peek_ok_ff, peek_ok_in;
   logic [DATA_W-1:0] rd_ff;

   logic              accept;
   logic              csr_write;
   logic [CNT_W-1:0]  cap_use;
   logic [IW-1:0]     tail_next;
   logic [IW-1:0]     head_next;
   logic              wr_en;
   logic [IW-1:0]     rd_addr;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cap_use = cap_ff;
      if (cap_ff == '0) begin
         cap_use = CNT_W'(1);
      end else if (int'(cap_ff) > DEPTH) begin
         cap_use = CNT_W'(DEPTH);
      end
   end

   assign tail_next = ((CMPW'(tail_ff) + CMPW'(1)) >= CMPW'(cap_use)) ? '0 : tail_ff + IW'(1);
   assign head_next = ((CMPW'(head_ff) + CMPW'(1)) >= CMPW'(cap_use)) ? '0 : head_ff + IW'(1);

   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      status_in  = ST_OK;
      peek_ok_in = 1'b0;
      wr_en      = 1'b0;
      case (req_command)
         CMD_INSERT: begin
            if (count_ff >= cap_use) begin
               status_in = ST_OVERFLOW;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
               if (count_ff == '0) begin
                  head_in = '0;
                  tail_in = '0;
               end else begin
                  tail_in = tail_next;
               end
            end
         end
         CMD_REMOVE: begin
            if (count_ff == '0) begin
               status_in = ST_UNDERFLOW;
            end else if (count_ff == CNT_W'(1)) begin
               head_in  = '0;
               tail_in  = '0;
               count_in = '0;
            end else begin
               head_in  = head_next;
               count_in = count_ff - CNT_W'(1);
            end
         end
         CMD_PEEK_FRONT, CMD_PEEK_REAR: begin
            if (count_ff == '0) begin
               status_in = ST_UNDERFLOW;
            end else begin
               peek_ok_in = 1'b1;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   assign rd_addr = (req_command == CMD_PEEK_FRONT) ? head_ff : tail_ff;

   always_ff @(posedge clock) begin
      if (accept && wr_en) begin
         slot_mem[tail_in] <= req_data_in;
      end
      if (accept) begin
         rd_ff <= slot_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (csr_write) begin
         cap_ff   <= csr_queue_capacity;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= status_in;
         rsp_count_ff  <= count_in;
         rsp_full_ff   <= (count_in == cap_use);
         rsp_empty_ff  <= (count_in == '0);
         peek_ok_ff    <= peek_ok_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value_out   = peek_ok_ff ? rd_ff : '0;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_full     = rsp_full_ff;
   assign rsp_is_empty    = rsp_empty_ff;

`ifndef SYNTHESIS
   a_count_within_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_use)
      else $error("entry count exceeds capacity in use");

   a_empty_pointers_home: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> head_ff == '0 && tail_ff == '0)
      else $error("empty queue with pointers away from slot zero");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OVERFLOW |-> rsp_is_full)
      else $error("overflow reported on a queue that is not full");

   a_csr_empties: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> count_ff == '0)
      else $error("capacity write did not empty the queue");

   a_value_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_value_out != '0 |-> rsp_status == ST_OK)
      else $error("nonzero value with an error status");
`endif

endmodule
